// ----- rtl/assert_macros.svh -----
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Implication checked in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/ldf_pkg.sv -----
package ldf_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam logic [31:0] MAX_PAYLOAD_LIMIT = 32'd32768;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd32768;

    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [1:0] CFG_ACCEPT_MASK = 2'd0;
    localparam logic [1:0] CFG_PING_TYPE   = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_PONG = 1'b1;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] sequence_res;
        logic [7:0]  data_byte;
        logic        last;
    } out_item_t;

endpackage

// ----- rtl/ldf_in_if.sv -----
interface ldf_in_if;
    import ldf_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ldf_out_if.sv -----
interface ldf_out_if;
    import ldf_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/length_prefixed_frame_deframer.sv -----
// Channel  Dir  Payload                                                    Handshake
// item     in   rx_byte[7:0], abort                                        valid/ready
// result   out  kind, frame_type, frame_flags, sequence_res, data_byte, last  valid/ready
// cfg      in   cfg_index[1:0], cfg_data[63:0]                             cfg_we, no wait
//
// One byte per cycle unless a result is held; bytes pass input reg, then result reg.
// The input register feeds one pass of parse logic that updates the header window
// and loads the result register; bytes that give no result still take one pass.
// A held result stalls the parse stage; an empty input register still takes one byte.
// Reset clears parser state and loads register defaults (max_payload = 32768).
`include "assert_macros.svh"

module length_prefixed_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    ldf_in_if.sink                        item,
    ldf_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldf_pkg::*;

    // configuration
    logic [63:0] accept_mask_reg;
    logic [7:0]  ping_type_reg;
    logic [15:0] max_payload_reg;

    // input stage
    logic     in_valid_reg;
    in_item_t in_data_reg;

    // parser state
    byte_t       window_reg [HEADER_BYTES];
    byte_t       window_next [HEADER_BYTES];
    logic [3:0]  header_count_reg, header_count_next;
    logic        in_payload_reg, in_payload_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    // result stage
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      res_valid;
    out_item_t res_data;

    logic        advance;
    byte_t       win_wr [HEADER_BYTES];
    logic [2:0]  hdr_idx;
    logic        hdr_full;
    logic [31:0] len;
    logic [31:0] eff_limit;
    logic        oversize;
    byte_t       ftype;
    logic        is_ping;
    logic        type_ok;
    logic        final_byte;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_mask_reg <= '0;
            ping_type_reg   <= '0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEPT_MASK: accept_mask_reg <= cfg_data[63:0];
                CFG_PING_TYPE:   ping_type_reg   <= cfg_data[7:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        hdr_idx = (header_count_reg >= 4'(HEADER_BYTES)) ? 3'd7 : header_count_reg[2:0];
        hdr_full = (hdr_idx == 3'd7);

        win_wr = window_reg;
        if (!in_payload_reg)
        begin
            win_wr[hdr_idx] = in_data_reg.rx_byte;
        end

        len = {win_wr[7], win_wr[6], win_wr[5], win_wr[4]};
        eff_limit = ({16'd0, max_payload_reg} > MAX_PAYLOAD_LIMIT) ?
                    MAX_PAYLOAD_LIMIT : {16'd0, max_payload_reg};
        oversize = (len > eff_limit);

        ftype      = win_wr[0];
        is_ping    = (ftype == ping_type_reg);
        type_ok    = (ftype[7:6] == 2'b00) && accept_mask_reg[ftype[5:0]];
        final_byte = (bytes_left_reg <= 16'd1);

        window_next       = window_reg;
        header_count_next = header_count_reg;
        in_payload_next   = in_payload_reg;
        bytes_left_next   = bytes_left_reg;
        res_valid         = 1'b0;

        res_data.kind         = KIND_DATA;
        res_data.frame_type   = win_wr[0];
        res_data.frame_flags  = win_wr[1];
        res_data.sequence_res = {win_wr[3], win_wr[2]};
        res_data.data_byte    = in_data_reg.rx_byte;
        res_data.last         = final_byte;

        if (in_data_reg.abort)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                window_next[i] = '0;
            end
            header_count_next = '0;
            in_payload_next   = 1'b0;
            bytes_left_next   = '0;
        end
        else if (in_payload_reg)
        begin
            if (final_byte)
            begin
                bytes_left_next   = '0;
                in_payload_next   = 1'b0;
                header_count_next = '0;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
            end
            // ping payload is swallowed; the pong goes out with the final byte
            if (is_ping)
            begin
                res_valid = final_byte;
                res_data.kind = KIND_PONG;
                res_data.data_byte = '0;
                res_data.last = 1'b0;
            end
            else
            begin
                res_valid = type_ok;
            end
        end
        else
        begin
            window_next = win_wr;
            header_count_next = {1'b0, hdr_idx} + 4'd1;
            if (hdr_full)
            begin
                if (oversize)
                begin
                    // drop the oldest byte and slide the window to resync
                    for (int i = 0; i < HEADER_BYTES - 1; i++)
                    begin
                        window_next[i] = win_wr[i + 1];
                    end
                    window_next[HEADER_BYTES - 1] = '0;
                    header_count_next = 4'(HEADER_BYTES - 1);
                end
                else if (len == 32'd0)
                begin
                    header_count_next = '0;
                    res_valid = is_ping;
                    res_data.kind = KIND_PONG;
                    res_data.data_byte = '0;
                    res_data.last = 1'b0;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    bytes_left_next = len[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_data_reg <= item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
            header_count_reg <= '0;
            in_payload_reg   <= 1'b0;
            bytes_left_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            window_reg       <= window_next;
            header_count_reg <= header_count_next;
            in_payload_reg   <= in_payload_next;
            bytes_left_reg   <= bytes_left_next;
            out_valid_reg    <= res_valid;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    `ASSERT_IMPLIES(a_payload_has_bytes, in_payload_reg, bytes_left_reg != 16'd0)
    `ASSERT_IMPLIES(a_payload_full_header, in_payload_reg,
                    header_count_reg == 4'(HEADER_BYTES))
    `ASSERT_IMPLIES(a_count_range, !in_payload_reg,
                    header_count_reg < 4'(HEADER_BYTES))
    `ASSERT_NEXT(a_abort_clears, advance && in_data_reg.abort,
                 !in_payload_reg && header_count_reg == 4'd0 && bytes_left_reg == 16'd0)
    `ASSERT_IMPLIES(a_pong_clean, out_valid_reg && out_data_reg.kind == KIND_PONG,
                    out_data_reg.data_byte == 8'd0 && !out_data_reg.last)

endmodule
